/* hw/rtl/ldpm_pkg.sv */
`default_nettype none

package ldpm_pkg;

  // Fixed-point formats
  localparam int COEF_FRAC_BITS = 20;
  localparam int NORM_INT_BITS  = 4;
  localparam int PIX_W          = 16;
  localparam int FOCAL_W        = 18;
  localparam int COEF_W         = 25;
  localparam int OUT_W          = 18;
  localparam int NORM_W         = COEF_FRAC_BITS + NORM_INT_BITS + 1;

  // Output clamp range, signed Q13.4
  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  // Normalizing divider: one quotient bit per step, several steps per stage
  localparam int DIV_STEPS     = COEF_FRAC_BITS + NORM_INT_BITS;
  localparam int DIV_PER_STAGE = 3;
  localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;

  // Wide multiplier: operand A split into a low and a high slice
  localparam int WA_W    = 58;
  localparam int WB_W    = 32;
  localparam int WSPLIT  = 29;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FOCAL_X   = 3'd0,
    REG_FOCAL_Y   = 3'd1,
    REG_PRINCIPAL = 3'd2,
    REG_K1        = 3'd3,
    REG_K2        = 3'd4,
    REG_K3        = 3'd5,
    REG_P1        = 3'd6,
    REG_P2        = 3'd7
  } reg_idx_t;

  // Partial state of the restoring divider
  typedef struct packed {
    logic [FOCAL_W-1:0]   rem;
    logic [DIV_STEPS-1:0] num;
    logic [DIV_STEPS-1:0] q;
  } div_st_t;

  // One restoring division step: shift in a dividend bit, try to subtract
  function automatic div_st_t div_step(input div_st_t s, input logic [FOCAL_W-1:0] f);
    logic [FOCAL_W:0] r2;
    div_st_t          o;
    r2    = {s.rem, s.num[DIV_STEPS-1]};
    o.num = s.num << 1;
    if (r2 >= {1'b0, f}) begin
      o.rem = FOCAL_W'(r2 - {1'b0, f});
      o.q   = {s.q[DIV_STEPS-2:0], 1'b1};
    end else begin
      o.rem = r2[FOCAL_W-1:0];
      o.q   = {s.q[DIV_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/lens_distortion_point_map.sv */
// Pipeline: 10 register stages of normalizing divider, 14 of distortion datapath.
// Throughput: one transaction per clock; busy stays low, the pipeline never stalls.
// Reset: synchronous active-low rst_n clears all valid bits and loads the
// configuration registers with focal lengths of 1.0 pixel and all other values zero.
`default_nettype none

module lens_distortion_point_map (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  output logic                                       busy,
  input  logic        [ldpm_pkg::PIX_W-1:0]          in_x,
  input  logic        [ldpm_pkg::PIX_W-1:0]          in_y,
  output logic                                       out_valid,
  output logic signed [ldpm_pkg::OUT_W-1:0]          out_x,
  output logic signed [ldpm_pkg::OUT_W-1:0]          out_y,
  output logic                                       out_clipped,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic        [ldpm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic        [ldpm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic        [ldpm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                       pready
);

  localparam int F    = ldpm_pkg::COEF_FRAC_BITS;
  localparam int NW   = ldpm_pkg::NORM_W;
  localparam int CW   = ldpm_pkg::COEF_W;
  localparam int FW   = ldpm_pkg::FOCAL_W;
  localparam int PW   = ldpm_pkg::PIX_W;
  localparam int OW   = ldpm_pkg::OUT_W;
  localparam int AW   = ldpm_pkg::WA_W;
  localparam int BW   = ldpm_pkg::WB_W;
  localparam int DW   = ldpm_pkg::CFG_DATA_W;
  localparam int SQ_W = 2 * NW - F;
  localparam int R2_W = SQ_W + 1;
  localparam int R4_W = 2 * R2_W - F;
  localparam int KR_W = CW + R2_W - F;
  localparam int T_W  = CW + SQ_W - F;
  localparam int S_W  = R2_W + 1;
  localparam int TP_W = CW + S_W - F;
  localparam int TX_W = TP_W + 1;
  localparam int LAT  = ldpm_pkg::DIV_STAGES + 16;
  localparam logic signed [AW-1:0] ONE_Q = AW'(64'd1 << F);
  localparam logic signed [AW:0]   PIX_HI = (AW+1)'(ldpm_pkg::OUT_MAX);
  localparam logic signed [AW:0]   PIX_LO = (AW+1)'(ldpm_pkg::OUT_MIN);

  // Configuration registers
  logic        [FW-1:0] focal_x_r, focal_y_r;
  logic        [DW-1:0] pp_r;
  logic signed [CW-1:0] k1_r, k2_r, k3_r, p1_r, p2_r;
  logic        [PW-1:0] cx, cy;
  logic                 cfg_wr;
  ldpm_pkg::reg_idx_t   cfg_idx;

  logic [LAT-1:0] vld_r;

  // Datapath
  logic signed [NW-1:0]     x0, y0;
  logic signed [NW-1:0]     x_d [1:8];
  logic signed [NW-1:0]     y_d [1:8];
  logic signed [2*NW-1:0]   xx_p, yy_p, xy_p;
  logic signed [SQ_W-1:0]   xx1_r, yy1_r, xy1_r, xx2_r, yy2_r, xy2_r;
  logic signed [R2_W-1:0]   r2_2_r, r2_3_r;
  logic signed [2*R2_W-1:0] r4_p;
  logic signed [CW+R2_W-1:0] k1_p;
  logic signed [CW+SQ_W-1:0] t1_p, t2_p;
  logic signed [R4_W-1:0]   r4_3_r;
  logic signed [KR_W-1:0]   k1r2_3_r, k1r2_4_r, k1r2_5_r;
  logic signed [T_W-1:0]    t1_3_r, t2_3_r, t1_4_r, t2_4_r;
  logic signed [S_W-1:0]    sx_3_r, sy_3_r;
  logic signed [CW+S_W-1:0] tpx_p, tpy_p;
  logic signed [TP_W-1:0]   tpx_4_r, tpy_4_r;
  logic signed [TX_W-1:0]   tx_d [5:10];
  logic signed [TX_W-1:0]   ty_d [5:10];
  logic signed [AW-1:0]     r6, k2r4, k3r6, rx, ry, fx, fy;
  logic signed [AW-1:0]     rs_6_r, rs_7_r, radial_r, xd_r, yd_r;
  logic signed [AW:0]       psum_x, psum_y;
  logic signed [OW-1:0]     out_x_r, out_y_r;
  logic                     clip_x, clip_y, out_clipped_r;
  logic signed [OW-1:0]     sat_x, sat_y;

  assign cx      = pp_r[PW-1:0];
  assign cy      = pp_r[2*PW-1:PW];
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = ldpm_pkg::reg_idx_t'(paddr[ldpm_pkg::CFG_ADDR_W-1:2]);
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r <= FW'(16);
      focal_y_r <= FW'(16);
      pp_r      <= '0;
      k1_r      <= '0;
      k2_r      <= '0;
      k3_r      <= '0;
      p1_r      <= '0;
      p2_r      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ldpm_pkg::REG_FOCAL_X:   focal_x_r <= pwdata[FW-1:0];
        ldpm_pkg::REG_FOCAL_Y:   focal_y_r <= pwdata[FW-1:0];
        ldpm_pkg::REG_PRINCIPAL: pp_r      <= pwdata;
        ldpm_pkg::REG_K1:        k1_r      <= pwdata[CW-1:0];
        ldpm_pkg::REG_K2:        k2_r      <= pwdata[CW-1:0];
        ldpm_pkg::REG_K3:        k3_r      <= pwdata[CW-1:0];
        ldpm_pkg::REG_P1:        p1_r      <= pwdata[CW-1:0];
        ldpm_pkg::REG_P2:        p2_r      <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      ldpm_pkg::REG_FOCAL_X:   prdata = DW'(focal_x_r);
      ldpm_pkg::REG_FOCAL_Y:   prdata = DW'(focal_y_r);
      ldpm_pkg::REG_PRINCIPAL: prdata = pp_r;
      ldpm_pkg::REG_K1:        prdata = DW'(unsigned'(k1_r));
      ldpm_pkg::REG_K2:        prdata = DW'(unsigned'(k2_r));
      ldpm_pkg::REG_K3:        prdata = DW'(unsigned'(k3_r));
      ldpm_pkg::REG_P1:        prdata = DW'(unsigned'(p1_r));
      ldpm_pkg::REG_P2:        prdata = DW'(unsigned'(p2_r));
      default:                 prdata = '0;
    endcase
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  // Normalize both coordinates
  ldpm_div u_div_x (.clk(clk), .pix(in_x), .ctr(cx), .focal(focal_x_r), .norm(x0));
  ldpm_div u_div_y (.clk(clk), .pix(in_y), .ctr(cy), .focal(focal_y_r), .norm(y0));

  // Narrow products
  always_comb begin
    xx_p  = x0 * x0;
    yy_p  = y0 * y0;
    xy_p  = x0 * y0;
    r4_p  = r2_2_r * r2_2_r;
    k1_p  = k1_r * r2_2_r;
    t1_p  = p1_r * xy2_r;
    t2_p  = p2_r * xy2_r;
    tpx_p = p2_r * sx_3_r;
    tpy_p = p1_r * sy_3_r;
  end

  // Distortion pipeline, stages counted from the normalized coordinates
  always_ff @(posedge clk) begin
    x_d[1] <= x0;
    y_d[1] <= y0;
    for (int i = 2; i <= 8; i++) begin
      x_d[i] <= x_d[i-1];
      y_d[i] <= y_d[i-1];
    end
    // squares and cross term
    xx1_r <= xx_p[F +: SQ_W];
    yy1_r <= yy_p[F +: SQ_W];
    xy1_r <= xy_p[F +: SQ_W];
    // r squared
    r2_2_r <= R2_W'(xx1_r) + R2_W'(yy1_r);
    xx2_r  <= xx1_r;
    yy2_r  <= yy1_r;
    xy2_r  <= xy1_r;
    // r^4, first radial term, tangential pieces
    r4_3_r   <= r4_p[F +: R4_W];
    r2_3_r   <= r2_2_r;
    k1r2_3_r <= k1_p[F +: KR_W];
    t1_3_r   <= t1_p[F +: T_W];
    t2_3_r   <= t2_p[F +: T_W];
    sx_3_r   <= S_W'(r2_2_r) + (S_W'(xx2_r) <<< 1);
    sy_3_r   <= S_W'(r2_2_r) + (S_W'(yy2_r) <<< 1);
    // tangential products
    tpx_4_r  <= tpx_p[F +: TP_W];
    tpy_4_r  <= tpy_p[F +: TP_W];
    t1_4_r   <= t1_3_r;
    t2_4_r   <= t2_3_r;
    k1r2_4_r <= k1r2_3_r;
    k1r2_5_r <= k1r2_4_r;
    tx_d[5]  <= (TX_W'(t1_4_r) <<< 1) + TX_W'(tpx_4_r);
    ty_d[5]  <= (TX_W'(t2_4_r) <<< 1) + TX_W'(tpy_4_r);
    for (int i = 6; i <= 10; i++) begin
      tx_d[i] <= tx_d[i-1];
      ty_d[i] <= ty_d[i-1];
    end
    // radial factor
    rs_6_r   <= ONE_Q + AW'(k1r2_5_r) + k2r4;
    rs_7_r   <= rs_6_r;
    radial_r <= rs_7_r + k3r6;
    // distorted normalized point
    xd_r <= rx + AW'(tx_d[10]);
    yd_r <= ry + AW'(ty_d[10]);
  end

  // Wide products
  ldpm_wmul u_mul_r6  (.clk(clk), .a(AW'(r4_3_r)), .b(BW'(r2_3_r)), .p(r6));
  ldpm_wmul u_mul_k2  (.clk(clk), .a(AW'(r4_3_r)), .b(BW'(k2_r)),   .p(k2r4));
  ldpm_wmul u_mul_k3  (.clk(clk), .a(r6),          .b(BW'(k3_r)),   .p(k3r6));
  ldpm_wmul u_mul_rx  (.clk(clk), .a(radial_r),    .b(BW'(x_d[8])), .p(rx));
  ldpm_wmul u_mul_ry  (.clk(clk), .a(radial_r),    .b(BW'(y_d[8])), .p(ry));
  ldpm_wmul u_mul_fx  (.clk(clk), .a(xd_r),
                       .b($signed(BW'(focal_x_r))), .p(fx));
  ldpm_wmul u_mul_fy  (.clk(clk), .a(yd_r),
                       .b($signed(BW'(focal_y_r))), .p(fy));

  // Back to pixels and clamp
  always_comb begin
    psum_x = (AW+1)'(fx) + $signed({{(AW+1-PW){1'b0}}, cx});
    psum_y = (AW+1)'(fy) + $signed({{(AW+1-PW){1'b0}}, cy});
    clip_x = 1'b0;
    clip_y = 1'b0;
    sat_x  = psum_x[OW-1:0];
    sat_y  = psum_y[OW-1:0];
    if (psum_x > PIX_HI) begin
      sat_x  = OW'(ldpm_pkg::OUT_MAX);
      clip_x = 1'b1;
    end else if (psum_x < PIX_LO) begin
      sat_x  = OW'(ldpm_pkg::OUT_MIN);
      clip_x = 1'b1;
    end
    if (psum_y > PIX_HI) begin
      sat_y  = OW'(ldpm_pkg::OUT_MAX);
      clip_y = 1'b1;
    end else if (psum_y < PIX_LO) begin
      sat_y  = OW'(ldpm_pkg::OUT_MIN);
      clip_y = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_x_r       <= sat_x;
    out_y_r       <= sat_y;
    out_clipped_r <= clip_x | clip_y;
  end

  assign out_valid   = vld_r[LAT-1];
  assign out_x       = out_x_r;
  assign out_y       = out_y_r;
  assign out_clipped = out_clipped_r;

`ifndef SYNTHESIS
  // every accepted transaction yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(LAT) out_valid)
    else $error("result missing after pipeline latency");

  // no result without a matching transaction
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without transaction");

  // a clipped result carries a rail value on at least one axis
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |->
      (out_x == OW'(ldpm_pkg::OUT_MAX) || out_x == OW'(ldpm_pkg::OUT_MIN) ||
       out_y == OW'(ldpm_pkg::OUT_MAX) || out_y == OW'(ldpm_pkg::OUT_MIN)))
    else $error("clip flag without saturated output");

  // a focal_x write lands in its register
  a_focal_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr && cfg_idx == ldpm_pkg::REG_FOCAL_X) |=> focal_x_r == $past(pwdata[FW-1:0]))
    else $error("focal_x write lost");
`endif

endmodule

`default_nettype wire

/* hw/rtl/ldpm_div.sv */
`default_nettype none

module ldpm_div (
  input  logic                                clk,
  input  logic        [ldpm_pkg::PIX_W-1:0]   pix,
  input  logic        [ldpm_pkg::PIX_W-1:0]   ctr,
  input  logic        [ldpm_pkg::FOCAL_W-1:0] focal,
  output logic signed [ldpm_pkg::NORM_W-1:0]  norm
);

  localparam int F     = ldpm_pkg::COEF_FRAC_BITS;
  localparam int PW    = ldpm_pkg::PIX_W;
  localparam int FW    = ldpm_pkg::FOCAL_W;
  localparam int NS    = ldpm_pkg::DIV_STAGES;
  localparam int STEPS = ldpm_pkg::DIV_STEPS;
  localparam int NW    = ldpm_pkg::NORM_W;
  localparam int MAG_W = PW + F;
  localparam int IB    = ldpm_pkg::NORM_INT_BITS;

  logic signed [PW:0]        d;
  logic        [PW-1:0]      absd;
  logic        [FW-1:0]      f_eff;
  logic        [MAG_W-1:0]   mag;
  logic                      sat;

  ldpm_pkg::div_st_t         st_r  [0:NS];
  logic                      neg_r [0:NS];
  logic                      sat_r [0:NS];
  logic        [FW-1:0]      f_r   [0:NS];
  logic signed [NW-1:0]      norm_r;
  logic signed [NW-1:0]      norm_nxt;

  // Offset from the principal point, magnitude and sign
  always_comb begin
    d     = $signed({1'b0, pix}) - $signed({1'b0, ctr});
    absd  = d[PW] ? PW'(-d) : PW'(d);
    f_eff = (focal == '0) ? FW'(1) : focal;
    mag   = {absd, {F{1'b0}}};
    // quotient reaches the clamp exactly when |d| >= f * 2^IB
    sat   = ({{(FW+IB-PW){1'b0}}, absd} >= {f_eff, {IB{1'b0}}});
  end

  // Load the first stage
  always_ff @(posedge clk) begin
    st_r[0].rem <= FW'(mag[MAG_W-1:STEPS]);
    st_r[0].num <= mag[STEPS-1:0];
    st_r[0].q   <= '0;
    neg_r[0]    <= d[PW];
    sat_r[0]    <= sat;
    f_r[0]      <= f_eff;
  end

  // Advance the division a few quotient bits per stage
  for (genvar s = 0; s < NS; s++) begin : g_stage
    ldpm_pkg::div_st_t t;
    always_comb begin
      t = st_r[s];
      for (int k = 0; k < ldpm_pkg::DIV_PER_STAGE; k++) begin
        t = ldpm_pkg::div_step(t, f_r[s]);
      end
    end
    always_ff @(posedge clk) begin
      st_r[s+1]  <= t;
      neg_r[s+1] <= neg_r[s];
      sat_r[s+1] <= sat_r[s];
      f_r[s+1]   <= f_r[s];
    end
  end

  // Apply sign and clamp to signed Q4.F
  always_comb begin
    if (sat_r[NS]) begin
      norm_nxt = neg_r[NS] ? {1'b1, {(NW-1){1'b0}}} : {1'b0, {(NW-1){1'b1}}};
    end else if (neg_r[NS]) begin
      norm_nxt = -$signed({1'b0, st_r[NS].q});
    end else begin
      norm_nxt = $signed({1'b0, st_r[NS].q});
    end
  end

  always_ff @(posedge clk) begin
    norm_r <= norm_nxt;
  end

  assign norm = norm_r;

endmodule

`default_nettype wire

/* hw/rtl/ldpm_wmul.sv */
`default_nettype none

module ldpm_wmul (
  input  logic                             clk,
  input  logic signed [ldpm_pkg::WA_W-1:0] a,
  input  logic signed [ldpm_pkg::WB_W-1:0] b,
  output logic signed [ldpm_pkg::WA_W-1:0] p
);

  localparam int AW    = ldpm_pkg::WA_W;
  localparam int BW    = ldpm_pkg::WB_W;
  localparam int S     = ldpm_pkg::WSPLIT;
  localparam int HW    = AW - S;
  localparam int FULLW = AW + BW;

  logic signed [S+BW:0]     plo_r;
  logic signed [HW+BW-1:0]  phi_r;
  logic signed [FULLW-1:0]  full;
  logic signed [AW-1:0]     p_r;

  // Form the two partial products
  always_ff @(posedge clk) begin
    plo_r <= $signed({1'b0, a[S-1:0]}) * b;
    phi_r <= $signed(a[AW-1:S]) * b;
  end

  // Combine and drop the fraction bits, rounding toward minus infinity
  always_comb begin
    full = (FULLW'(phi_r) <<< S) + FULLW'(plo_r);
  end

  always_ff @(posedge clk) begin
    p_r <= full[ldpm_pkg::COEF_FRAC_BITS +: AW];
  end

  assign p = p_r;

endmodule

`default_nettype wire
